// ===== sv/sha256_message_digest_macros.svh =====
// assertion macros for the sha-256 digest checker
// no dependencies; include by bare file name
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SHA256MD_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sha256md: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SHA256MD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sha256md: next-cycle check failed");

`endif

// ===== sv/sha256md_pkg.sv =====
// shared types, constants and round functions for the sha-256 digest block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sha256md_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned HASH_WORDS  = 8;
	localparam int unsigned NUM_ROUNDS  = 64;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [2:0] FULL_BYTES = 3'd4;
	localparam logic [2:0] LAST_INDEX = 3'(HASH_WORDS - 1);
	localparam logic [5:0] LAST_ROUND = 6'(NUM_ROUNDS - 1);
	localparam logic [3:0] LAST_FILL  = 4'(BLOCK_WORDS - 1);
	localparam logic [3:0] LEN_FILL   = 4'(BLOCK_WORDS - 2);

	localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] HASH_INIT [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	// sequencer commands to the schedule and round units
	typedef struct packed {
		logic        push;
		logic [31:0] push_word;
		logic        load;
		logic        round;
		logic        add;
		logic        init;
		logic [5:0]  round_idx;
	} ctl_t;

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
		input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ===== sv/sha256md_in_if.sv =====
// message word channel: valid/ready handshake with the input word fields
// no dependencies
`timescale 1ns / 1ps

interface sha256md_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic        last_of_message;

	modport source (output valid, data_word, valid_bytes, last_of_message, input ready);
	modport sink   (input valid, data_word, valid_bytes, last_of_message, output ready);
endinterface

// ===== sv/sha256md_out_if.sv =====
// digest word channel: valid/ready handshake with the digest word fields
// no dependencies
`timescale 1ns / 1ps

interface sha256md_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        last_of_digest;

	modport source (output valid, digest_word, digest_index, last_of_digest, input ready);
	modport sink   (input valid, digest_word, digest_index, last_of_digest, output ready);
endinterface

// ===== sv/sha256md_sched.sv =====
// block buffer and message schedule: 16-word window shifted once per push or round
// depends on sha256md_pkg
`timescale 1ns / 1ps

module sha256md_sched
	import sha256md_pkg::*;
(
	input  logic        clk,
	input  ctl_t        ctl,
	output logic [31:0] w_t
);

	logic [31:0] w_q [BLOCK_WORDS];
	logic [31:0] w_next;
	logic [31:0] shift_in;

	// next schedule word from the current window
	always_comb begin
		w_next   = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
		shift_in = ctl.push ? ctl.push_word : w_next;
	end

	// window shifts toward index 0; oldest word feeds the round
	always_ff @(posedge clk) begin
		if (ctl.push || ctl.round) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= shift_in;
		end
	end

	assign w_t = w_q[0];

endmodule

// ===== sv/sha256md_round.sv =====
// compression round unit and chaining hash registers
// depends on sha256md_pkg
`timescale 1ns / 1ps

module sha256md_round
	import sha256md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic [31:0] w_t,
	input  logic [2:0]  rd_idx,
	output logic [31:0] rd_word
);

	logic [31:0] hash_q [HASH_WORDS];
	logic [31:0] work_q [HASH_WORDS];
	logic [31:0] t1;
	logic [31:0] t2;

	// one round of the compression function
	always_comb begin
		t1 = work_q[7] + big_sigma1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6])
			+ ROUND_K[ctl.round_idx] + w_t;
		t2 = big_sigma0(work_q[0]) + majority(work_q[0], work_q[1], work_q[2]);
	end

	// working variables a..h
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			work_q <= hash_q;
		end else if (ctl.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	// chaining value, back to the initial value after a digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_INIT;
		end else if (ctl.init) begin
			hash_q <= HASH_INIT;
		end else if (ctl.add) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				hash_q[i] <= hash_q[i] + work_q[i];
			end
		end
	end

	assign rd_word = hash_q[rd_idx];

endmodule

// ===== sv/sha256md_ctrl.sv =====
// sequencer: word intake, padding, round count, bit count and digest readout
// depends on sha256md_pkg
`timescale 1ns / 1ps

module sha256md_ctrl
	import sha256md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  digest_index,
	output logic        last_of_digest,
	output ctl_t        ctl
);

	state_t      state_q, state_d;
	logic [3:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        need_pad_q;
	logic        padding_q;
	logic        hi_done_q;
	logic        tail_done_q;

	logic [2:0]  vb_sat;
	logic [31:0] first_word;
	logic [31:0] pad_word;
	logic        take;
	logic        emit_done;

	// final word: mask unused bytes and merge the pad byte unless all four bytes are valid
	always_comb begin
		vb_sat = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
		case (vb_sat)
			3'd0:    first_word = {PAD_BYTE, 24'd0};
			3'd1:    first_word = {data_word[31:24], PAD_BYTE, 16'd0};
			3'd2:    first_word = {data_word[31:16], PAD_BYTE, 8'd0};
			3'd3:    first_word = {data_word[31:8], PAD_BYTE};
			default: first_word = data_word;
		endcase
	end

	// padding words: pad byte if pending, zeros, then the 64-bit length
	always_comb begin
		if (need_pad_q) begin
			pad_word = {PAD_BYTE, 24'd0};
		end else if (hi_done_q) begin
			pad_word = bits_q[31:0];
		end else if (fill_q == LEN_FILL) begin
			pad_word = bits_q[63:32];
		end else begin
			pad_word = '0;
		end
	end

	// outputs per state
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		ctl           = '0;
		ctl.round_idx = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.push      = 1'b1;
					ctl.push_word = last_of_message ? first_word : data_word;
				end
			end
			ST_PAD: begin
				ctl.push      = 1'b1;
				ctl.push_word = pad_word;
			end
			ST_ROUND: begin
				ctl.round = 1'b1;
			end
			ST_ADD: begin
				ctl.add = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				ctl.init  = out_ready && (idx_q == LAST_INDEX);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		ctl.load = ctl.push && (fill_q == LAST_FILL);
	end

	assign take      = in_valid && in_ready;
	assign emit_done = ctl.init;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (ctl.load) begin
						state_d = ST_ROUND;
					end else if (last_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (ctl.load) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (tail_done_q) begin
					state_d = ST_EMIT;
				end else if (padding_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bits_q      <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			need_pad_q  <= 1'b0;
			padding_q   <= 1'b0;
			hi_done_q   <= 1'b0;
			tail_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push) begin
				fill_q <= fill_q + 4'd1;
			end
			if (ctl.load) begin
				rnd_q <= '0;
			end else if (ctl.round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			// message length in bits, wrapping
			if (take) begin
				if (last_of_message) begin
					bits_q     <= bits_q + 64'({vb_sat, 3'b000});
					need_pad_q <= (vb_sat == FULL_BYTES);
					padding_q  <= 1'b1;
				end else begin
					bits_q <= bits_q + 64'(WORD_W);
				end
			end
			// padding progress
			if (state_q == ST_PAD) begin
				if (need_pad_q) begin
					need_pad_q <= 1'b0;
				end else if (hi_done_q) begin
					tail_done_q <= 1'b1;
				end else if (fill_q == LEN_FILL) begin
					hi_done_q <= 1'b1;
				end
			end
			// digest readout, then back to a fresh message
			if (out_valid && out_ready) begin
				idx_q <= idx_q + 3'd1;
			end
			if (emit_done) begin
				fill_q      <= '0;
				bits_q      <= '0;
				padding_q   <= 1'b0;
				hi_done_q   <= 1'b0;
				tail_done_q <= 1'b0;
			end
		end
	end

	assign digest_index   = idx_q;
	assign last_of_digest = (idx_q == LAST_INDEX);

endmodule

// ===== sv/sha256_message_digest.sv =====
// sha-256 digest: one word transfer per cycle while a block fills; the 16th word
// of a block holds ready low through its 64 rounds and the hash update, so the
// next block waits on the single round unit. final word: 2 to 18 padding
// pushes, one or two compressions, then eight digest transfers. async reset
// loads the initial hash and clears counts; the block buffer is not cleared.
`timescale 1ns / 1ps

module sha256_message_digest
	import sha256md_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	sha256md_in_if.sink    message,
	sha256md_out_if.source digest
);

	ctl_t        ctl;
	logic [31:0] w_t;
	logic [2:0]  idx;

	// sequencer
	sha256md_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (message.valid),
		.in_ready        (message.ready),
		.data_word       (message.data_word),
		.valid_bytes     (message.valid_bytes),
		.last_of_message (message.last_of_message),
		.out_valid       (digest.valid),
		.out_ready       (digest.ready),
		.digest_index    (idx),
		.last_of_digest  (digest.last_of_digest),
		.ctl             (ctl)
	);

	// block buffer and schedule
	sha256md_sched u_sched (
		.clk (clk),
		.ctl (ctl),
		.w_t (w_t)
	);

	// round unit and hash state
	sha256md_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.w_t     (w_t),
		.rd_idx  (idx),
		.rd_word (digest.digest_word)
	);

	assign digest.digest_index = idx;

endmodule

// ===== sv/sha256md_checker.sv =====
// port-level checks for the sha-256 digest block, bound to the top level
// depends on sha256_message_digest_macros.svh
`timescale 1ns / 1ps
`include "sha256_message_digest_macros.svh"

module sha256md_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  digest_index,
	input logic        last_of_digest
);

	// intake and readout never overlap
	`SHA256MD_ASSERT_SAME(a_no_overlap, clk, arst_n, 1'b1, !(in_ready && out_valid))

	// a final word transfer always drops ready while the block is padded or compressed
	`SHA256MD_ASSERT_NEXT(a_last_busy, clk, arst_n, in_valid && in_ready && in_last, !in_ready)

	// digest words come back to back in index order
	`SHA256MD_ASSERT_NEXT(a_index_step, clk, arst_n,
		out_valid && out_ready && !last_of_digest,
		out_valid && (digest_index == $past(digest_index) + 3'd1))

	// nothing follows the eighth digest word
	`SHA256MD_ASSERT_NEXT(a_digest_end, clk, arst_n,
		out_valid && out_ready && last_of_digest, !out_valid)

	// stalled digest word holds
	`SHA256MD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(digest_word) && $stable(digest_index))

endmodule

bind sha256_message_digest sha256md_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (message.valid),
	.in_ready       (message.ready),
	.in_last        (message.last_of_message),
	.out_valid      (digest.valid),
	.out_ready      (digest.ready),
	.digest_word    (digest.digest_word),
	.digest_index   (digest.digest_index),
	.last_of_digest (digest.last_of_digest)
);
